// ===== rtl/core/sktd_pkg.sv =====
// ----------------------------------------------------------------------------
// sktd_pkg: shared types and constants for the sorted key table
// Field widths, command and status codes, sequencer states, compare result.
// ----------------------------------------------------------------------------
package sktd_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 56;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int DATE_W   = DAY_W + MONTH_W + YEAR_W;
  localparam int WORD_W   = KEY_W + DATE_W;
  localparam int RANK_W   = 7;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 8;

  localparam int TABLE_DEPTH_DEF = 128;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_PURGE  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_PUT,
    ST_RD_WAIT,
    ST_PG_RDI,
    ST_PG_LDI,
    ST_PG_SCAN,
    ST_RESP
  } state_t;

  // result of the shared comparator: a < b, a == b
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// ===== rtl/core/sktd_if.sv =====
// ----------------------------------------------------------------------------
// sktd_if: command and result channels of the sorted key table
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sktd_in_if;
  logic                         valid;
  logic                         ready;
  logic [sktd_pkg::CMD_W-1:0]   command;
  logic [sktd_pkg::KEY_W-1:0]   record_key;
  logic [sktd_pkg::DAY_W-1:0]   birth_day;
  logic [sktd_pkg::MONTH_W-1:0] birth_month;
  logic [sktd_pkg::YEAR_W-1:0]  birth_year;
  logic [sktd_pkg::RANK_W-1:0]  read_rank;

  modport source (
    output valid, command, record_key, birth_day, birth_month, birth_year, read_rank,
    input  ready
  );
  modport sink (
    input  valid, command, record_key, birth_day, birth_month, birth_year, read_rank,
    output ready
  );
endinterface

interface sktd_out_if;
  logic                          valid;
  logic                          ready;
  logic [sktd_pkg::STATUS_W-1:0] status;
  logic [sktd_pkg::KEY_W-1:0]    out_key;
  logic [sktd_pkg::DAY_W-1:0]    out_day;
  logic [sktd_pkg::MONTH_W-1:0]  out_month;
  logic [sktd_pkg::YEAR_W-1:0]   out_year;
  logic [sktd_pkg::ENTRY_W-1:0]  entry_count;

  modport source (
    output valid, status, out_key, out_day, out_month, out_year, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_key, out_day, out_month, out_year, entry_count,
    output ready
  );
endinterface

// ===== rtl/core/sktd_ram.sv =====
// ----------------------------------------------------------------------------
// sktd_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sktd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sktd_cmp.sv =====
// ----------------------------------------------------------------------------
// sktd_cmp: shared unsigned magnitude comparator
// Used for key ordering on insert and date match on purge.
// ----------------------------------------------------------------------------
module sktd_cmp (
  input  logic [sktd_pkg::KEY_W-1:0] a,
  input  logic [sktd_pkg::KEY_W-1:0] b,
  output sktd_pkg::cmp_res_t         res
);

  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end

endmodule

// ===== rtl/core/sorted_key_table_with_date_dedup_core.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_with_date_dedup_core: sorted record table with date purge
// Table of key/date records in ascending key order, one command per word.
// ----------------------------------------------------------------------------
// Usage: each command word yields exactly one result word. Records live in
// one RAM (key and packed date per entry, registered read), kept sorted by
// rank, and a small sequencer walks it one entry per cycle through a single
// shared comparator. Insert scans down from the top entry, moving each entry
// up one slot until the insertion point, where the new record is written; an
// insert into a full table returns the full status without scanning. Read
// returns the entry at the given rank, or the range status when the rank is
// not below the live count. Purge checks each entry against every later one
// for a matching date and compacts survivors in place.
// The command channel is ready only while the sequencer is idle; a finished
// result sits in the output register, so the next command can be taken
// while the previous result is still waiting. No clearing pass is needed
// after reset: entries above the live count are never read.
// ----------------------------------------------------------------------------
module sorted_key_table_with_date_dedup_core #(
  parameter int TABLE_DEPTH = sktd_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sktd_in_if.sink    in_chan,
  sktd_out_if.source out_chan
);

  localparam int IW     = $clog2(TABLE_DEPTH);       // entry address
  localparam int CW     = $clog2(TABLE_DEPTH + 1);   // live count
  localparam int RCW    = (CW > sktd_pkg::RANK_W) ? CW : sktd_pkg::RANK_W;
  localparam int KEY_W  = sktd_pkg::KEY_W;
  localparam int DATE_W = sktd_pkg::DATE_W;
  localparam int WORD_W = sktd_pkg::WORD_W;
  localparam int ECW    = sktd_pkg::ENTRY_W;
  localparam int DAY_W  = sktd_pkg::DAY_W;
  localparam int MON_W  = sktd_pkg::MONTH_W;
  localparam int YEAR_W = sktd_pkg::YEAR_W;

  // sequencer and table state
  sktd_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     m_r, m_nxt;          // insert scan position
  logic [CW-1:0]     i_r, i_nxt;          // purge outer index
  logic [CW-1:0]     j_r, j_nxt;          // purge inner index
  logic [CW-1:0]     kept_r, kept_nxt;    // purge compaction slot
  logic [WORD_W-1:0] hold_r, hold_nxt;    // record being placed / checked

  // pending result
  logic [sktd_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [WORD_W-1:0]             res_word_r, res_word_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [sktd_pkg::STATUS_W-1:0] out_status_r;
  logic [WORD_W-1:0]             out_word_r;
  logic [ECW-1:0]                out_count_r;
  logic                          out_load;

  // RAM port
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // shared comparator
  logic [KEY_W-1:0]   cmp_a;
  logic [KEY_W-1:0]   cmp_b;
  sktd_pkg::cmp_res_t cmp_res;

  logic [KEY_W-1:0]  rd_key;
  logic [DATE_W-1:0] rd_date;
  logic [KEY_W-1:0]  hold_key;
  logic [DATE_W-1:0] hold_date;
  logic [WORD_W-1:0] in_word;
  logic              in_fire;
  logic              ins_shift;

  assign rd_key    = ram_rdata[WORD_W-1 -: KEY_W];
  assign rd_date   = ram_rdata[DATE_W-1:0];
  assign hold_key  = hold_r[WORD_W-1 -: KEY_W];
  assign hold_date = hold_r[DATE_W-1:0];

  // packed date: day in the low bits, then month, then year
  assign in_word = {in_chan.record_key, in_chan.birth_year,
                    in_chan.birth_month, in_chan.birth_day};

  assign in_chan.ready = (state_r == sktd_pkg::ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  sktd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sktd_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // Compare operands: key order while inserting, date match while purging.
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state_r)
      sktd_pkg::ST_INS_SCAN: begin
        cmp_a = rd_key;
        cmp_b = hold_key;
      end
      sktd_pkg::ST_PG_SCAN: begin
        cmp_a = KEY_W'(rd_date);
        cmp_b = KEY_W'(hold_date);
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  // Table stays sorted, so an entry at rank m >= 1 moves up iff its key is
  // not below the new key; at rank 0 it moves only if strictly greater
  // (an equal key at rank 0 puts the new record at rank 1).
  assign ins_shift = (m_r == '0) ? (!cmp_res.lt && !cmp_res.eq) : !cmp_res.lt;

  assign out_load = (state_r == sktd_pkg::ST_RESP) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    m_nxt          = m_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    kept_nxt       = kept_r;
    hold_nxt       = hold_r;
    res_status_nxt = res_status_r;
    res_word_nxt   = res_word_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = hold_r;
    ram_raddr      = '0;

    case (state_r)
      sktd_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_status_nxt = sktd_pkg::STAT_OK;
          res_word_nxt   = '0;
          case (in_chan.command)
            sktd_pkg::CMD_INSERT: begin
              hold_nxt = in_word;
              if (count_r == CW'(TABLE_DEPTH)) begin
                res_status_nxt = sktd_pkg::STAT_FULL;
                state_nxt      = sktd_pkg::ST_RESP;
              end else if (count_r == '0) begin
                state_nxt = sktd_pkg::ST_INS_PUT;
              end else begin
                // start at the top entry and work down
                ram_raddr = IW'(count_r - 1'b1);
                m_nxt     = IW'(count_r - 1'b1);
                state_nxt = sktd_pkg::ST_INS_SCAN;
              end
            end
            sktd_pkg::CMD_READ: begin
              if (RCW'(in_chan.read_rank) >= RCW'(count_r)) begin
                res_status_nxt = sktd_pkg::STAT_RANGE;
                state_nxt      = sktd_pkg::ST_RESP;
              end else begin
                ram_raddr = IW'(in_chan.read_rank);
                state_nxt = sktd_pkg::ST_RD_WAIT;
              end
            end
            sktd_pkg::CMD_PURGE: begin
              i_nxt     = '0;
              kept_nxt  = '0;
              state_nxt = sktd_pkg::ST_PG_RDI;
            end
            default: begin
              state_nxt = sktd_pkg::ST_RESP;
            end
          endcase
        end
      end

      // read data is entry m; move it up or drop the new record above it
      sktd_pkg::ST_INS_SCAN: begin
        ram_we = 1'b1;
        ram_waddr = m_r + 1'b1;
        if (ins_shift) begin
          ram_wdata = ram_rdata;
          if (m_r == '0) begin
            state_nxt = sktd_pkg::ST_INS_PUT;
          end else begin
            ram_raddr = m_r - 1'b1;
            m_nxt     = m_r - 1'b1;
          end
        end else begin
          ram_wdata = hold_r;
          count_nxt = count_r + 1'b1;
          state_nxt = sktd_pkg::ST_RESP;
        end
      end

      // new record goes to rank 0
      sktd_pkg::ST_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = hold_r;
        count_nxt = count_r + 1'b1;
        state_nxt = sktd_pkg::ST_RESP;
      end

      sktd_pkg::ST_RD_WAIT: begin
        res_word_nxt = ram_rdata;
        state_nxt    = sktd_pkg::ST_RESP;
      end

      // purge: fetch entry i, or finish when all entries are checked
      sktd_pkg::ST_PG_RDI: begin
        if (i_r == count_r) begin
          count_nxt = kept_r;
          state_nxt = sktd_pkg::ST_RESP;
        end else begin
          ram_raddr = IW'(i_r);
          state_nxt = sktd_pkg::ST_PG_LDI;
        end
      end

      sktd_pkg::ST_PG_LDI: begin
        hold_nxt = ram_rdata;
        if ((i_r + 1'b1) < count_r) begin
          ram_raddr = IW'(i_r + 1'b1);
          j_nxt     = i_r + 1'b1;
          state_nxt = sktd_pkg::ST_PG_SCAN;
        end else begin
          // last entry never has a later match: keep it
          ram_we    = 1'b1;
          ram_waddr = IW'(kept_r);
          ram_wdata = ram_rdata;
          kept_nxt  = kept_r + 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = sktd_pkg::ST_PG_RDI;
        end
      end

      // read data is entry j; a date match drops entry i
      sktd_pkg::ST_PG_SCAN: begin
        if (cmp_res.eq) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = sktd_pkg::ST_PG_RDI;
        end else if ((j_r + 1'b1) < count_r) begin
          ram_raddr = IW'(j_r + 1'b1);
          j_nxt     = j_r + 1'b1;
        end else begin
          // slot kept <= i, so later entries are not disturbed
          ram_we    = 1'b1;
          ram_waddr = IW'(kept_r);
          ram_wdata = hold_r;
          kept_nxt  = kept_r + 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = sktd_pkg::ST_PG_RDI;
        end
      end

      sktd_pkg::ST_RESP: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = sktd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sktd_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sktd_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    m_r          <= m_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    kept_r       <= kept_nxt;
    hold_r       <= hold_nxt;
    res_status_r <= res_status_nxt;
    res_word_r   <= res_word_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_word_r   <= res_word_r;
      out_count_r  <= ECW'(count_r);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.out_key     = out_word_r[WORD_W-1 -: KEY_W];
  assign out_chan.out_day     = out_word_r[DAY_W-1:0];
  assign out_chan.out_month   = out_word_r[DAY_W +: MON_W];
  assign out_chan.out_year    = out_word_r[DAY_W + MON_W +: YEAR_W];
  assign out_chan.entry_count = out_count_r;

endmodule
